// File: hw/rtl/indexed_array_insert_search_defines.svh
// assertion macros shared by the indexed array insert and search block
// no dependencies; included by the top level
`ifndef INDEXED_ARRAY_INSERT_SEARCH_DEFINES_SVH
`define INDEXED_ARRAY_INSERT_SEARCH_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define IAIS_ASSERT_IMPL(lbl, clk, rst_n, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) else $error(msg);

// next-cycle implication
`define IAIS_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`else

`define IAIS_ASSERT_IMPL(lbl, clk, rst_n, pre, post, msg)
`define IAIS_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg)

`endif

`endif

// File: hw/rtl/iais_pkg.sv
// types and constants of the indexed array insert and search block
// no dependencies; imported by every module of the block but iais_ram
`timescale 1ns / 1ps

package iais_pkg;

  localparam int unsigned KIND_W  = 2;
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned POS_W   = 7;
  localparam int unsigned FOUND_W = 6;
  localparam int unsigned COUNT_W = 7;

  typedef enum logic [KIND_W-1:0] {
    KIND_APPEND = 2'd0,
    KIND_INSERT = 2'd1,
    KIND_READ   = 2'd2,
    KIND_SEARCH = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_RANGE    = 2'd1,
    ST_FULL     = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_e;

  typedef struct packed {
    kind_e                     kind;
    logic signed [VALUE_W-1:0] value;
    logic [POS_W-1:0]          position;
  } in_t;

  typedef struct packed {
    status_e                   status;
    logic signed [VALUE_W-1:0] read_value;
    logic [FOUND_W-1:0]        found_index;
    logic [COUNT_W-1:0]        count;
  } out_t;

  typedef enum logic [3:0] {
    DP_NONE,
    DP_CAPTURE,
    DP_APPEND,
    DP_INSERT,
    DP_SHIFT_START,
    DP_SHIFT,
    DP_READ_START,
    DP_SEARCH_START,
    DP_SEARCH
  } dp_op_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_SHIFT,
    S_INS_WRITE,
    S_READ,
    S_SEARCH,
    S_EMIT
  } state_e;

  typedef struct packed {
    dp_op_e  op;
    logic    set_status;
    status_e status;
    logic    take_read;
    logic    take_found;
    logic    emit;
  } cmd_t;

  typedef struct packed {
    kind_e kind;
    logic  full;
    logic  pos_gt_used;
    logic  pos_eq_used;
    logic  used_zero;
    logic  shift_last;
    logic  match;
    logic  search_last;
    logic  out_free;
  } sts_t;

endpackage

// File: hw/rtl/iais_ram.sv
// generic simple dual-port ram, one write and one registered read per cycle
// no dependencies
`timescale 1ns / 1ps

module iais_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// File: hw/rtl/iais_datapath.sv
// datapath: request register, entry count, array ram, shift and scan pointers,
// result register; depends on iais_pkg and iais_ram
`timescale 1ns / 1ps

module iais_datapath import iais_pkg::*; #(
  parameter int unsigned DEPTH      = 64,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  in_t  in_data_i,
  input  cmd_t cmd_i,
  output sts_t sts_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  output out_t out_data_o
);

  localparam int unsigned IdxW = $clog2(DEPTH);
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam int unsigned CmpW = (CntW > POS_W) ? CntW : POS_W;

  in_t                   req_q;
  logic [CntW-1:0]       used_q;
  logic [IdxW-1:0]       dst_q;
  logic [IdxW-1:0]       cmp_q;
  status_e               res_status_q;
  logic [VALUE_W-1:0]    res_rd_q;
  logic [FOUND_W-1:0]    res_found_q;
  out_t                  out_q;
  logic                  out_valid_q;

  logic [DATA_WIDTH-1:0] val_w;
  logic [CmpW-1:0]       pos_x;
  logic [CmpW-1:0]       used_x;
  logic                  ram_we;
  logic [IdxW-1:0]       ram_waddr;
  logic [DATA_WIDTH-1:0] ram_wdata;
  logic [IdxW-1:0]       ram_raddr;
  logic [DATA_WIDTH-1:0] ram_rdata;

  assign val_w  = DATA_WIDTH'($signed(req_q.value));
  assign pos_x  = CmpW'(req_q.position);
  assign used_x = CmpW'(used_q);

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = used_q[IdxW-1:0];
    ram_wdata = val_w;
    ram_raddr = '0;
    unique case (cmd_i.op)
      DP_APPEND: begin
        ram_we = 1'b1;
      end
      DP_INSERT: begin
        ram_we    = 1'b1;
        ram_waddr = pos_x[IdxW-1:0];
      end
      DP_SHIFT_START: begin
        ram_raddr = IdxW'(used_q - CntW'(1));
      end
      DP_SHIFT: begin
        ram_we    = 1'b1;
        ram_waddr = dst_q;
        ram_wdata = ram_rdata;
        ram_raddr = dst_q - IdxW'(2);
      end
      DP_READ_START: begin
        ram_raddr = pos_x[IdxW-1:0];
      end
      DP_SEARCH: begin
        ram_raddr = cmp_q + IdxW'(1);
      end
      DP_NONE, DP_CAPTURE, DP_SEARCH_START: begin
        ram_raddr = '0;
      end
      default: begin
        ram_raddr = '0;
      end
    endcase
  end

  iais_ram #(
    .WIDTH(DATA_WIDTH),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q      <= '0;
      dst_q       <= '0;
      cmp_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.op == DP_APPEND || cmd_i.op == DP_INSERT) begin
        used_q <= used_q + CntW'(1);
      end
      if (cmd_i.op == DP_SHIFT_START) begin
        dst_q <= used_q[IdxW-1:0];
      end else if (cmd_i.op == DP_SHIFT) begin
        dst_q <= dst_q - IdxW'(1);
      end
      if (cmd_i.op == DP_SEARCH_START) begin
        cmp_q <= '0;
      end else if (cmd_i.op == DP_SEARCH) begin
        cmp_q <= cmp_q + IdxW'(1);
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.op == DP_CAPTURE) begin
      req_q        <= in_data_i;
      res_status_q <= ST_OK;
      res_rd_q     <= '0;
      res_found_q  <= '0;
    end else begin
      if (cmd_i.set_status) begin
        res_status_q <= cmd_i.status;
      end
      if (cmd_i.take_read) begin
        res_rd_q <= VALUE_W'($signed(ram_rdata));
      end
      if (cmd_i.take_found) begin
        res_found_q <= FOUND_W'(cmp_q);
      end
    end
    if (cmd_i.emit) begin
      out_q.status      <= res_status_q;
      out_q.read_value  <= res_rd_q;
      out_q.found_index <= res_found_q;
      out_q.count       <= COUNT_W'(used_q);
    end
  end

  always_comb begin
    sts_o.kind        = req_q.kind;
    sts_o.full        = (used_q == CntW'(DEPTH));
    sts_o.pos_gt_used = (pos_x > used_x);
    sts_o.pos_eq_used = (pos_x == used_x);
    sts_o.used_zero   = (used_q == '0);
    sts_o.shift_last  = (CmpW'(dst_q) == pos_x + CmpW'(1));
    sts_o.match       = (ram_rdata == val_w);
    sts_o.search_last = (CntW'(cmp_q) == used_q - CntW'(1));
    sts_o.out_free    = !out_valid_q || out_ready_i;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// File: hw/rtl/iais_ctrl.sv
// controller: state machine that sequences each request over the datapath
// depends on iais_pkg
`timescale 1ns / 1ps

module iais_ctrl import iais_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  state_e state_q;
  state_e state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d          = state_q;
    in_ready_o       = 1'b0;
    cmd_o.op         = DP_NONE;
    cmd_o.set_status = 1'b0;
    cmd_o.status     = ST_OK;
    cmd_o.take_read  = 1'b0;
    cmd_o.take_found = 1'b0;
    cmd_o.emit       = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.op = DP_CAPTURE;
          state_d  = S_DECODE;
        end
      end
      S_DECODE: begin
        state_d = S_EMIT;
        unique case (sts_i.kind)
          KIND_APPEND: begin
            if (sts_i.full) begin
              cmd_o.set_status = 1'b1;
              cmd_o.status     = ST_FULL;
            end else begin
              cmd_o.op = DP_APPEND;
            end
          end
          KIND_INSERT: begin
            priority if (sts_i.full) begin
              cmd_o.set_status = 1'b1;
              cmd_o.status     = ST_FULL;
            end else if (sts_i.pos_gt_used) begin
              cmd_o.set_status = 1'b1;
              cmd_o.status     = ST_RANGE;
            end else if (sts_i.pos_eq_used) begin
              cmd_o.op = DP_INSERT;
            end else begin
              cmd_o.op = DP_SHIFT_START;
              state_d  = S_SHIFT;
            end
          end
          KIND_READ: begin
            if (sts_i.pos_gt_used || sts_i.pos_eq_used) begin
              cmd_o.set_status = 1'b1;
              cmd_o.status     = ST_RANGE;
            end else begin
              cmd_o.op = DP_READ_START;
              state_d  = S_READ;
            end
          end
          KIND_SEARCH: begin
            if (sts_i.used_zero) begin
              cmd_o.set_status = 1'b1;
              cmd_o.status     = ST_NOTFOUND;
            end else begin
              cmd_o.op = DP_SEARCH_START;
              state_d  = S_SEARCH;
            end
          end
          default: begin
            state_d = S_EMIT;
          end
        endcase
      end
      S_SHIFT: begin
        cmd_o.op = DP_SHIFT;
        if (sts_i.shift_last) begin
          state_d = S_INS_WRITE;
        end
      end
      S_INS_WRITE: begin
        cmd_o.op = DP_INSERT;
        state_d  = S_EMIT;
      end
      S_READ: begin
        cmd_o.take_read = 1'b1;
        state_d         = S_EMIT;
      end
      S_SEARCH: begin
        priority if (sts_i.match) begin
          cmd_o.take_found = 1'b1;
          state_d          = S_EMIT;
        end else if (sts_i.search_last) begin
          cmd_o.set_status = 1'b1;
          cmd_o.status     = ST_NOTFOUND;
          state_d          = S_EMIT;
        end else begin
          cmd_o.op = DP_SEARCH;
        end
      end
      S_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

// File: hw/rtl/indexed_array_insert_search.sv
// Indexed array with append, insert, read and linear search. One request is
// handled at a time; the next is taken once the current result sits in the
// output register, even if that result has not yet been taken. Append, an
// insert at the end of the array, any full or index error, and a search of an
// empty array are settled when the request is decoded; a read waits on the
// ram's registered read port; an insert at index p below the n entries stored
// moves the entries from p up by one, one entry moved per cycle through the
// array ram's single write port; a search scans from index 0 to a match or the
// last entry, one entry compared per cycle off the ram's registered read port.
// The array ram holds no reset; only entries below the count are ever used.
// Depends on iais_pkg, iais_ctrl, iais_datapath and the defines header.
`timescale 1ns / 1ps
`include "indexed_array_insert_search_defines.svh"

module indexed_array_insert_search import iais_pkg::*; #(
  parameter int unsigned DEPTH      = 64,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output out_t out_data_o
);

  cmd_t cmd;
  sts_t sts;

  iais_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  iais_datapath #(
    .DEPTH     (DEPTH),
    .DATA_WIDTH(DATA_WIDTH)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (in_data_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  // one request at a time
  `IAIS_ASSERT_NEXT(a_one_at_a_time, clk_i, rst_ni, in_valid_i && in_ready_o, !in_ready_o, "request accepted while busy")

  // a waiting result is never overwritten
  `IAIS_ASSERT_IMPL(a_no_overwrite, clk_i, rst_ni, cmd.emit, sts.out_free, "result overwritten")

  // full status only with a full array
  `IAIS_ASSERT_IMPL(a_full_count, clk_i, rst_ni, out_valid_o && out_data_o.status == ST_FULL, out_data_o.count == COUNT_W'(DEPTH), "full status with room left")

  // failed requests carry zero data
  `IAIS_ASSERT_IMPL(a_err_zero, clk_i, rst_ni, out_valid_o && out_data_o.status != ST_OK, out_data_o.read_value == '0 && out_data_o.found_index == '0, "error result carries data")

endmodule

// File: tb/iais_array_checker.sv
// result checker for the indexed array insert and search block
// mirrors the array and its length, predicts each result and compares it
// depends on iais_pkg
`timescale 1ns / 1ps

module iais_array_checker import iais_pkg::*; #(
  parameter int unsigned DEPTH      = 64,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  logic in_ready_i,
  input  in_t  in_data_i,
  input  logic out_valid_i,
  input  logic out_ready_i,
  input  out_t out_data_i,
  output int   fail_count_o,
  output int   pending_o
);

  logic [DATA_WIDTH-1:0] shadow_mem [DEPTH];
  int unsigned           shadow_len;
  out_t                  predicted_q [$];
  int                    fail_count;

  function automatic out_t array_apply(in_t req);
    out_t                         res;
    logic signed [63:0]           wide;
    logic [DATA_WIDTH-1:0]        entry;
    logic signed [DATA_WIDTH-1:0] held;
    bit                           hit;
    int                           i;
    wide = req.value;
    entry = wide[DATA_WIDTH-1:0];
    res.status = ST_OK;
    res.read_value = '0;
    res.found_index = '0;
    case (req.kind)
      KIND_APPEND: begin
        if (shadow_len >= DEPTH) begin
          res.status = ST_FULL;
        end else begin
          shadow_mem[shadow_len] = entry;
          shadow_len++;
        end
      end
      KIND_INSERT: begin
        if (shadow_len >= DEPTH) begin
          res.status = ST_FULL;
        end else if (req.position > shadow_len) begin
          res.status = ST_RANGE;
        end else begin
          for (i = shadow_len; i > req.position; i--) begin
            shadow_mem[i] = shadow_mem[i-1];
          end
          shadow_mem[req.position] = entry;
          shadow_len++;
        end
      end
      KIND_READ: begin
        if (req.position >= shadow_len) begin
          res.status = ST_RANGE;
        end else begin
          held = shadow_mem[req.position];
          wide = held;
          res.read_value = wide[VALUE_W-1:0];
        end
      end
      default: begin
        res.status = ST_NOTFOUND;
        hit = 1'b0;
        for (i = 0; i < shadow_len; i++) begin
          if (!hit && shadow_mem[i] == entry) begin
            hit = 1'b1;
            res.status = ST_OK;
            res.found_index = i[FOUND_W-1:0];
          end
        end
      end
    endcase
    res.count = shadow_len[COUNT_W-1:0];
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    out_t want;
    if (!rst_ni) begin
      shadow_len = 0;
      fail_count = 0;
      predicted_q.delete();
      fail_count_o <= 0;
      pending_o <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (predicted_q.size() == 0) begin
          $error("result with no request pending");
          fail_count++;
        end else begin
          want = predicted_q.pop_front();
          if (out_data_i.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, out_data_i.status);
            fail_count++;
          end
          if (out_data_i.read_value !== want.read_value) begin
            $error("read_value: expected %0d, actual %0d", want.read_value,
                   out_data_i.read_value);
            fail_count++;
          end
          if (out_data_i.found_index !== want.found_index) begin
            $error("found_index: expected %0d, actual %0d", want.found_index,
                   out_data_i.found_index);
            fail_count++;
          end
          if (out_data_i.count !== want.count) begin
            $error("count: expected %0d, actual %0d", want.count, out_data_i.count);
            fail_count++;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        predicted_q.push_back(array_apply(in_data_i));
      end
      fail_count_o <= fail_count;
      pending_o <= predicted_q.size();
    end
  end

endmodule

// File: tb/testbench.sv
// top of the indexed array insert and search testbench: clock, reset, stimulus
// and verdict; depends on iais_pkg, the block and iais_array_checker
`timescale 1ns / 1ps

module testbench;
  import iais_pkg::*;

  localparam int unsigned STALL_LIMIT = 5000;
  localparam int unsigned HOLD_CYCLES = 200;
  localparam int unsigned TAIL_CYCLES = 100;
  localparam int unsigned PHASE_ITEMS = 400;

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_ready_o;
  in_t  in_data_i;
  logic out_valid_o;
  logic out_ready_i;
  out_t out_data_o;

  int                 fail_count;
  int                 pending;
  int                 send_idle;
  int                 recv_idle;
  bit                 hold_req;
  logic [COUNT_W-1:0] seen_count;
  int                 quiet_cycles;
  logic signed [VALUE_W-1:0] value_pool [16];

  indexed_array_insert_search u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  iais_array_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_i   (in_ready_o),
    .in_data_i    (in_data_i),
    .out_valid_i  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_data_i   (out_data_o),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // length of the array as last reported, steers positions
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_count <= '0;
    end else if (out_valid_o && out_ready_i) begin
      seen_count <= out_data_o.count;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quiet_cycles <= 0;
    end else if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("[indexed_array_insert_search] ERROR");
        $finish;
      end
    end
  end

  initial begin
    out_ready_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_req = 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(0, 99) >= recv_idle);
      end
    end
  end

  task automatic send_req(in_t req);
    in_valid_i <= 1'b1;
    in_data_i <= req;
    do @(posedge clk_i); while (!in_ready_o);
    if ($urandom_range(0, 99) < send_idle) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(0, 99) < send_idle) @(posedge clk_i);
    end
  endtask

  task automatic put(kind_e k, logic signed [VALUE_W-1:0] v, logic [POS_W-1:0] p);
    in_t req;
    req.kind = k;
    req.value = v;
    req.position = p;
    send_req(req);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  function automatic in_t next_random();
    in_t req;
    int  r;
    int  c;
    c = seen_count;
    r = $urandom_range(0, 99);
    if (r < 10) begin
      req.kind = KIND_APPEND;
    end else if (r < 25) begin
      req.kind = KIND_INSERT;
    end else if (r < 60) begin
      req.kind = KIND_READ;
    end else begin
      req.kind = KIND_SEARCH;
    end
    if ($urandom_range(0, 99) < 70) begin
      req.value = value_pool[$urandom_range(0, 15)];
    end else begin
      req.value = $urandom;
    end
    r = $urandom_range(0, 99);
    if (r < 70) begin
      req.position = POS_W'($urandom_range(0, c));
    end else if (r < 85) begin
      req.position = POS_W'(c + $urandom_range(0, 1));
    end else begin
      req.position = POS_W'($urandom_range(0, 127));
    end
    return req;
  endfunction

  initial begin
    int ph;
    int n;
    rst_ni <= 1'b0;
    in_valid_i <= 1'b0;
    in_data_i <= '0;
    send_idle = 29;
    recv_idle = 77;
    hold_req = 1'b0;
    value_pool[0] = 0;
    value_pool[1] = -1;
    value_pool[2] = 32'sh8000_0000;
    value_pool[3] = 32'sh7fff_ffff;
    for (n = 4; n < 16; n++) begin
      value_pool[n] = $urandom;
    end
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty array, then edges of insert, read and search
    put(KIND_READ, 0, 0);
    put(KIND_SEARCH, 0, 0);
    put(KIND_INSERT, 5, 1);
    put(KIND_INSERT, 32'sh7fff_ffff, 0);
    put(KIND_APPEND, 32'sh8000_0000, 0);
    put(KIND_INSERT, -1, 2);
    put(KIND_INSERT, 0, 1);
    put(KIND_INSERT, 7, 127);
    put(KIND_INSERT, 7, 5);
    put(KIND_APPEND, -1, 127);
    put(KIND_READ, 0, 0);
    put(KIND_READ, 0, 4);
    put(KIND_READ, 0, 5);
    put(KIND_READ, 0, 127);
    put(KIND_SEARCH, -1, 0);
    put(KIND_SEARCH, 32'sh8000_0000, 0);
    put(KIND_SEARCH, 12345, 0);
    put(KIND_SEARCH, 32'sh7fff_ffff, 0);
    put(KIND_INSERT, 32'sh5555_5555, 0);
    put(KIND_APPEND, 32'shaaaa_aaaa, 0);
    put(KIND_READ, 0, 0);
    put(KIND_READ, 0, 6);
    drain();

    for (ph = 0; ph < 3; ph++) begin
      if (ph == 1) begin
        send_idle = 77;
        recv_idle = 29;
        hold_req = 1'b1;
      end else if (ph == 2) begin
        send_idle = 0;
        recv_idle = 0;
      end
      for (n = 0; n < PHASE_ITEMS; n++) begin
        send_req(next_random());
      end
      drain();
    end

    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("[indexed_array_insert_search] OK");
    end else begin
      $display("[indexed_array_insert_search] ERROR");
    end
    $finish;
  end

endmodule
